/* hdl/lir_pkg.sv */
// Shared types and constants of the linear interpolation resampler.
`default_nettype none

package lir_pkg;

    localparam int OPCODE_BITS = 2;
    localparam logic [OPCODE_BITS-1:0] OPC_LOAD    = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OPC_EMIT    = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OPC_RESTART = 2'd2;

    localparam int RATIO_BITS  = 24;
    localparam int LENGTH_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = RATIO_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH = 1'b1;
    localparam logic [RATIO_BITS-1:0]  RATIO_RESET  = 24'd65536;
    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 16'd4096;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_EMIT,
        CMD_RESTART
    } cmd_kind_t;

    typedef struct packed {
        logic      valid;
        cmd_kind_t kind;
    } cmd_t;

endpackage

`default_nettype wire

/* hdl/lir_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none

module lir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/lir_front.sv */
// Front end: accepts input words, decodes the opcode and queues commands.
`default_nettype none

module lir_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lir_pkg::OPCODE_BITS-1:0]  s_opcode,
    input  wire logic [SAMPLE_BITS-1:0]           s_sample,
    output lir_pkg::cmd_t                         cmd,
    output logic      [SAMPLE_BITS-1:0]           cmd_sample,
    input  wire logic                             cmd_pop
);

    import lir_pkg::*;

    cmd_kind_t                 q_kind_reg   [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0]    q_sample_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    cmd_kind_t                 kind_dec;
    logic                      known;
    logic                      push;

    // Opcode 3 is dropped here and never reaches the back end.
    always_comb begin
        kind_dec = CMD_LOAD;
        known    = 1'b1;
        case (s_opcode)
            OPC_LOAD:    kind_dec = CMD_LOAD;
            OPC_EMIT:    kind_dec = CMD_EMIT;
            OPC_RESTART: kind_dec = CMD_RESTART;
            default:     known    = 1'b0;
        endcase
    end

    assign s_tready   = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready && known;
    assign cmd.valid  = (count_reg != '0);
    assign cmd.kind   = q_kind_reg[rd_ptr_reg];
    assign cmd_sample = q_sample_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && cmd_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_kind_reg[wr_ptr_reg]   <= kind_dec;
            q_sample_reg[wr_ptr_reg] <= s_sample;
        end
    end

endmodule

`default_nettype wire

/* hdl/lir_back.sv */
// Back end: sample buffer, read position and the interpolation datapath.
`default_nettype none

module lir_back #(
    parameter int BUFFER_DEPTH = 4096,
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_BITS  = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire lir_pkg::cmd_t                   cmd,
    input  wire logic [SAMPLE_BITS-1:0]          cmd_sample,
    output logic                                 cmd_pop,
    input  wire logic [lir_pkg::RATIO_BITS-1:0]  ratio,
    input  wire logic [lir_pkg::LENGTH_BITS-1:0] length,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [SAMPLE_BITS-1:0]          m_sample,
    output logic                                 m_tlast
);

    import lir_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int CW  = $clog2(BUFFER_DEPTH + 1);
    localparam int PIB = $clog2(BUFFER_DEPTH + (1 << (RATIO_BITS - FRAC_BITS)));
    localparam int PB  = PIB + FRAC_BITS;
    localparam int PW  = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int HW  = SAMPLE_BITS + 2;
    localparam int HPW = HW + RATIO_BITS + 1;
    localparam int LPW = FRAC_BITS + RATIO_BITS;
    localparam int TW  = HPW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_B,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           loaded_reg;
    logic [PB-1:0]           pos_reg;
    logic [LENGTH_BITS-1:0]  emit_cnt_reg;
    logic                    last_reg;
    logic                    zero_reg;
    logic                    b_ok_reg;
    logic [AW-1:0]           addr_b_reg;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic [SAMPLE_BITS-1:0]  a_reg;
    logic signed [PW-1:0]    pa_reg;
    logic signed [PW-1:0]    pb_reg;
    logic signed [PW-1:0]    interp_reg;
    logic signed [HPW-1:0]   hp_reg;
    logic [LPW-1:0]          lp_reg;
    logic                    m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]  m_sample_reg;
    logic                    m_tlast_reg;

    logic                    ram_en;
    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [SAMPLE_BITS-1:0]  ram_rdata;

    logic [PIB-1:0]          idx;
    logic [PIB:0]            idx_inc;
    logic                    in_range;
    logic                    b_ok_next;
    logic [PB-1:0]           pos_next;
    logic [LENGTH_BITS-1:0]  emit_cnt_next;
    logic [FRAC_BITS:0]      wa;
    logic [SAMPLE_BITS-1:0]  b_val;
    logic signed [PW-1:0]    pa_next;
    logic signed [PW-1:0]    pb_next;
    logic signed [PW-1:0]    interp_next;
    logic signed [HPW-1:0]   hp_next;
    logic [LPW-1:0]          lp_next;
    logic signed [TW-1:0]    t_sum;
    logic signed [TW-1:0]    t_floor;
    logic [TW-SAMPLE_BITS:0] upper;
    logic [SAMPLE_BITS-1:0]  sat_val;
    logic                    out_free;

    lir_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd_sample),
        .rdata (ram_rdata)
    );

    assign idx       = pos_reg[PB-1:FRAC_BITS];
    assign idx_inc   = {1'b0, idx} + (PIB+1)'(1);
    assign in_range  = idx < PIB'(loaded_reg);
    assign b_ok_next = idx_inc < (PIB+1)'(loaded_reg);
    assign pos_next  = pos_reg + PB'(ratio);
    assign emit_cnt_next = (emit_cnt_reg == '1) ? emit_cnt_reg : emit_cnt_reg + 1'b1;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd.valid;

    // Weights of the left and right neighbour.
    assign wa      = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_reg};
    assign b_val   = b_ok_reg ? ram_rdata : '0;
    assign pa_next = $signed(a_reg) * $signed({1'b0, wa});
    assign pb_next = $signed(b_val) * $signed({1'b0, frac_reg});
    assign interp_next = pa_reg + pb_reg;

    // The interpolated value is split at the binary point so that each
    // scaling product stays within one multiplier.
    assign hp_next = $signed(interp_reg[PW-1:FRAC_BITS]) * $signed({1'b0, ratio});
    assign lp_next = interp_reg[FRAC_BITS-1:0] * ratio;

    assign t_sum   = {hp_reg[HPW-1], hp_reg} + TW'(lp_reg[LPW-1:FRAC_BITS]);
    assign t_floor = t_sum >>> FRAC_BITS;
    assign upper   = t_floor[TW-1:SAMPLE_BITS-1];
    assign sat_val = ((&upper) || !(|upper)) ? t_floor[SAMPLE_BITS-1:0] :
                     (t_floor[TW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                                      {1'b0, {(SAMPLE_BITS-1){1'b1}}});
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = idx[AW-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (cmd.valid) begin
                    case (cmd.kind)
                        CMD_LOAD: begin
                            ram_addr = loaded_reg[AW-1:0];
                            ram_en   = (loaded_reg < DEPTH_C);
                            ram_we   = 1'b1;
                        end
                        CMD_EMIT: ram_en = in_range;
                        default: ;
                    endcase
                end
            end
            ST_READ_B: begin
                ram_en   = 1'b1;
                ram_addr = addr_b_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            loaded_reg   <= '0;
            pos_reg      <= '0;
            emit_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd.valid) begin
                        case (cmd.kind)
                            CMD_LOAD: begin
                                if (loaded_reg < DEPTH_C) begin
                                    loaded_reg <= loaded_reg + 1'b1;
                                end
                            end
                            CMD_RESTART: begin
                                loaded_reg   <= '0;
                                pos_reg      <= '0;
                                emit_cnt_reg <= '0;
                            end
                            CMD_EMIT: begin
                                emit_cnt_reg <= emit_cnt_next;
                                last_reg     <= (emit_cnt_next >= length);
                                frac_reg     <= pos_reg[FRAC_BITS-1:0];
                                addr_b_reg   <= idx_inc[AW-1:0];
                                b_ok_reg     <= b_ok_next;
                                zero_reg     <= !in_range;
                                if (in_range) begin
                                    pos_reg   <= pos_next;
                                    state_reg <= ST_READ_B;
                                end else begin
                                    state_reg <= ST_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ_B: begin
                    a_reg     <= ram_rdata;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    pa_reg    <= pa_next;
                    pb_reg    <= pb_next;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    interp_reg <= interp_next;
                    state_reg  <= ST_SCALE;
                end
                ST_SCALE: begin
                    hp_reg    <= hp_next;
                    lp_reg    <= lp_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_sample_reg <= zero_reg ? '0 : sat_val;
                        m_tlast_reg  <= last_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_sample = m_sample_reg;
    assign m_tlast  = m_tlast_reg;

    a_loaded_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= DEPTH_C)
        else $error("loaded count beyond buffer depth");

    a_read_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ_B) |-> (loaded_reg != '0) && !zero_reg)
        else $error("interpolation started on an empty buffer");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && cmd.kind == CMD_RESTART) |=>
            (loaded_reg == '0) && (pos_reg == '0) && (emit_cnt_reg == '0))
        else $error("restart did not clear the buffer state");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !out_free) |=> (state_reg == ST_OUT))
        else $error("result dropped while the output word was held");

endmodule

`default_nettype wire

/* hdl/linear_interp_resampler_top.sv */
// Top level of the linear interpolation resampler.
//
// Input words arrive on the s_ channel: s_tuser carries the opcode (load a
// sample, emit an output, restart) and s_tdata the sample for a load. Each
// emit yields one word on the m_ channel with the resampled sample in
// m_tdata and m_tlast high once the run length has been reached. The
// cfg_ channel writes the rate ratio (index 0) and the run length (index 1)
// and is always ready.
// A two-entry command queue separates the input side from the execution
// unit, so input words are taken while a result waits on a stalled output.
// Load and restart are handled in the idle state of the execution unit; an
// emit inside the loaded data passes two reads of the single-port sample
// buffer, then the product, sum, scaling and saturation stages, and an emit
// past the data goes straight to the output stage. An accepted emit word
// passes through the command queue before the execution unit takes it.
// When the receiver stalls, the result is held and the execution unit
// waits once the output register is full.
// Reset empties the queue, the buffer and the position, and sets the ratio
// to 1.0 and the run length to 4096.
`default_nettype none

module linear_interp_resampler_top #(
    parameter int BUFFER_DEPTH = 4096,
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_BITS  = 24,
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [TDATA_BITS-1:0]               s_tdata,   // sample_in
    input  wire logic [lir_pkg::OPCODE_BITS-1:0]     s_tuser,   // opcode
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [TDATA_BITS-1:0]               m_tdata,   // sample_out
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [lir_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import lir_pkg::*;

    logic [RATIO_BITS-1:0]  ratio_reg;
    logic [LENGTH_BITS-1:0] length_reg;
    cmd_t                   cmd;
    logic [SAMPLE_BITS-1:0] cmd_sample;
    logic                   cmd_pop;
    logic [SAMPLE_BITS-1:0] m_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg  <= RATIO_RESET;
            length_reg <= LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RATIO:  ratio_reg  <= cfg_data[RATIO_BITS-1:0];
                REG_LENGTH: length_reg <= cfg_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    lir_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_opcode   (s_tuser),
        .s_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .cmd        (cmd),
        .cmd_sample (cmd_sample),
        .cmd_pop    (cmd_pop)
    );

    lir_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cmd_sample (cmd_sample),
        .cmd_pop    (cmd_pop),
        .ratio      (ratio_reg),
        .length     (length_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_sample   (m_sample),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = TDATA_BITS'(m_sample);

endmodule

`default_nettype wire
